// ----- hw/rtl/tls_sni_extractor_unit_defines.svh -----
// Assertion macros used by the SNI extractor result queue.
// Include in modules that carry concurrent checks; no other dependencies.
`ifndef TLS_SNI_EXTRACTOR_UNIT_DEFINES_SVH
`define TLS_SNI_EXTRACTOR_UNIT_DEFINES_SVH
// Implication checked on every edge outside reset.
`define TSE_ASSERT_IMP(lbl, ck, rn, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) else $error(msg);
// Next-cycle implication outside reset.
`define TSE_ASSERT_NXT(lbl, ck, rn, a, c, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) else $error(msg);
`endif

// ----- hw/rtl/tse_pkg.sv -----
// Package for the SNI extractor: result type and shared constants.
// No dependencies.
package tse_pkg;
  localparam int unsigned MAX_HOST_LEN_DEF = 255;
  localparam int unsigned OFFSET_BITS_DEF  = 16;
  localparam logic [15:0] MATCH_PORT_RST   = 16'd443;
  localparam logic [15:0] PARSE_DEPTH_RST  = 16'd512;
  localparam logic [7:0]  EXT_LIMIT_RST    = 8'd32;
  localparam logic [1:0]  CFG_MATCH_PORT   = 2'd0;
  localparam logic [1:0]  CFG_PARSE_DEPTH  = 2'd1;
  localparam logic [1:0]  CFG_EXT_LIMIT    = 2'd2;
  localparam logic [2:0]  VC_NOT_TCP   = 3'd0;
  localparam logic [2:0]  VC_NOT_HELLO = 3'd1;
  localparam logic [2:0]  VC_NO_SNI    = 3'd2;
  localparam logic [2:0]  VC_BAD_SNI   = 3'd3;
  localparam logic [2:0]  VC_SNI_OK    = 3'd4;

  typedef struct packed {
    logic        is_verdict;
    logic [7:0]  host_char;
    logic [7:0]  host_index;
    logic [2:0]  verdict_code;
    logic [7:0]  sni_len;
    logic [31:0] dest_addr;
  } tse_res_t;
endpackage

// ----- hw/rtl/tls_sni_extractor_unit.sv -----
// Top level of the TLS SNI extractor: config registers, parser, result queue.
// Depends on tse_pkg, tse_parser and tse_result_fifo.
//   channel  | dir | ports
//   in_      | in  | in_valid, in_stall, in_frame_byte, in_frame_end
//   out_     | out | out_valid, out_stall, out_is_verdict .. out_dest_addr
//   cfg_     | in  | cfg_we, cfg_index, cfg_wdata
// One byte per cycle while in_stall is low; a beat yields at most two results into a 4-entry queue.
// Results are queued at the accepting edge and offered in order, one per cycle while out_stall is low.
// in_stall rises only when the queue holds more than two results.
// Reset is synchronous; registers return to 443/512/32, parser to Ethernet phase.
module tls_sni_extractor_unit import tse_pkg::*; #(
  parameter int unsigned MAX_HOST_LEN = MAX_HOST_LEN_DEF,
  parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_verdict,
  output logic [7:0]  out_host_char,
  output logic [7:0]  out_host_index,
  output logic [2:0]  out_verdict_code,
  output logic [7:0]  out_sni_len,
  output logic [31:0] out_dest_addr,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  logic [15:0] port_r, depth_r;
  logic [7:0]  lim_r;
  logic        room, step, v0, v1;
  tse_res_t    r0, r1, q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_r <= MATCH_PORT_RST; depth_r <= PARSE_DEPTH_RST; lim_r <= EXT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_PORT:  port_r  <= cfg_wdata;
        CFG_PARSE_DEPTH: depth_r <= cfg_wdata;
        CFG_EXT_LIMIT:   lim_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !room;
  assign step = in_valid && room;

  tse_parser #(.MAX_HOST_LEN(MAX_HOST_LEN), .OFFSET_BITS(OFFSET_BITS)) u_parser (
    .clk, .rst_n, .step, .frame_byte(in_frame_byte), .frame_end(in_frame_end),
    .match_port(port_r), .parse_depth(depth_r), .ext_limit(lim_r),
    .res0_vld(v0), .res1_vld(v1), .res0(r0), .res1(r1)
  );

  tse_result_fifo u_fifo (
    .clk, .rst_n, .wr0(v0), .wr1(v1), .d0(r0), .d1(r1), .room,
    .out_valid, .out_stall, .q
  );

  assign out_is_verdict   = q.is_verdict;
  assign out_host_char    = q.host_char;
  assign out_host_index   = q.host_index;
  assign out_verdict_code = q.verdict_code;
  assign out_sni_len      = q.sni_len;
  assign out_dest_addr    = q.dest_addr;
endmodule

// ----- hw/rtl/tse_parser.sv -----
// Front end: byte-serial frame parser producing up to two results per beat.
// Depends on tse_pkg.
module tse_parser import tse_pkg::*; #(
  parameter int unsigned MAX_HOST_LEN = MAX_HOST_LEN_DEF,
  parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  input  logic [15:0] match_port,
  input  logic [15:0] parse_depth,
  input  logic [7:0]  ext_limit,
  output logic        res0_vld,
  output logic        res1_vld,
  output tse_res_t    res0,
  output tse_res_t    res1
);
  localparam int unsigned PW = OFFSET_BITS + 2;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [8:0] HMAX = 9'(MAX_HOST_LEN);

  typedef enum logic [3:0] {
    PH_ETH, PH_IP, PH_TCP, PH_TLS, PH_SID, PH_CSLEN, PH_CMLEN, PH_EXTLEN,
    PH_EXTHDR, PH_EXTSKIP, PH_SNI, PH_NAME, PH_DONE
  } phase_t;

  phase_t           ph_r, ph_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [PW-1:0]    tgt_r, tgt_nxt, ps_r, ps_nxt, xend_r, xend_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [7:0]       xcnt_r, xcnt_nxt, hlen_r, hlen_nxt, hcnt_r, hcnt_nxt;
  logic [31:0]      dest_r, dest_nxt;
  logic [2:0]       vc_r, vc_nxt;

  logic [PW-1:0] p, r, pos, lim;
  logic [15:0]   v;
  logic          is_host;
  logic [2:0]    ecode;
  logic [7:0]    lc;

  assign p   = PW'(off_r);
  assign r   = p - tgt_r;
  assign v   = {acc_r[7:0], frame_byte};
  assign lim = ps_r + PW'(parse_depth);

  always_comb begin
    unique case (ph_r)
      PH_DONE: ecode = vc_r;
      PH_ETH, PH_IP, PH_TCP: ecode = VC_NOT_TCP;
      PH_TLS: ecode = VC_NOT_HELLO;
      PH_SNI, PH_NAME: ecode = VC_BAD_SNI;
      default: ecode = VC_NO_SNI;
    endcase
  end

  assign lc = (frame_byte >= 8'h41 && frame_byte <= 8'h5a) ? frame_byte + 8'd32 : frame_byte;

  always_comb begin
    phase_t ph_e;
    logic [2:0] vc_e;
    logic [31:0] dest_e;
    ph_nxt = ph_r; off_nxt = off_r; tgt_nxt = tgt_r; ps_nxt = ps_r;
    xend_nxt = xend_r; acc_nxt = acc_r; xcnt_nxt = xcnt_r; hlen_nxt = hlen_r;
    hcnt_nxt = hcnt_r; dest_nxt = dest_r; vc_nxt = vc_r;
    is_host = 1'b0; pos = '0;
    if (off_r == OFF_MAX) begin
      if (ph_r != PH_DONE) begin
        if (ph_r == PH_IP) dest_nxt = '0;
        vc_nxt = ecode; ph_nxt = PH_DONE;
      end
    end else begin
      off_nxt = off_r + 1'b1;
      if (ph_r != PH_DONE && p >= tgt_r) begin
        unique case (ph_r)
          PH_ETH: begin
            if (r == 12) acc_nxt = {8'd0, frame_byte};
            else if (r == 13) begin
              if (v != 16'h0800) begin vc_nxt = VC_NOT_TCP; ph_nxt = PH_DONE; end
              else ph_nxt = PH_IP;
            end
          end
          PH_IP: begin
            if (r == 14) begin
              if (frame_byte[3:0] < 4'd5) begin
                dest_nxt = '0; vc_nxt = VC_NOT_TCP; ph_nxt = PH_DONE;
              end else ps_nxt = PW'(14) + PW'({frame_byte[3:0], 2'b00});
            end else if (r == 23) begin
              if (frame_byte != 8'd6) begin
                dest_nxt = '0; vc_nxt = VC_NOT_TCP; ph_nxt = PH_DONE;
              end
            end else if (r >= 30 && r <= 33) begin
              dest_nxt = {dest_r[23:0], frame_byte};
              if (r == 33) begin ph_nxt = PH_TCP; tgt_nxt = ps_r; end
            end
          end
          PH_TCP: begin
            if (r == 2) acc_nxt = {8'd0, frame_byte};
            else if (r == 3) begin
              if (v != match_port) begin vc_nxt = VC_NOT_TCP; ph_nxt = PH_DONE; end
            end else if (r == 12) begin
              if (frame_byte[7:4] < 4'd5) begin vc_nxt = VC_NOT_TCP; ph_nxt = PH_DONE; end
              else acc_nxt = {10'd0, frame_byte[7:4], 2'b00};
            end else if (r == 19) begin
              ps_nxt = tgt_r + PW'(acc_r); tgt_nxt = tgt_r + PW'(acc_r); ph_nxt = PH_TLS;
            end
          end
          PH_TLS: begin
            if (r == 0) begin
              if (frame_byte != 8'd22) begin vc_nxt = VC_NOT_HELLO; ph_nxt = PH_DONE; end
            end else if (r == 1) acc_nxt = {8'd0, frame_byte};
            else if (r == 2) begin
              if (v != 16'h0301 && v != 16'h0302 && v != 16'h0303) begin
                vc_nxt = VC_NOT_HELLO; ph_nxt = PH_DONE;
              end
            end else if (r == 5) begin
              if (frame_byte != 8'd1) begin vc_nxt = VC_NOT_HELLO; ph_nxt = PH_DONE; end
            end else if (r == 8) begin
              pos = ps_r + PW'(43);
              if (pos > lim) begin vc_nxt = VC_NO_SNI; ph_nxt = PH_DONE; end
              else begin ph_nxt = PH_SID; tgt_nxt = pos; end
            end
          end
          PH_SID, PH_CMLEN: begin
            pos = p + PW'(1) + PW'(frame_byte);
            if (pos > lim) begin vc_nxt = VC_NO_SNI; ph_nxt = PH_DONE; end
            else begin ph_nxt = (ph_r == PH_SID) ? PH_CSLEN : PH_EXTLEN; tgt_nxt = pos; end
          end
          PH_CSLEN: begin
            if (r == 0) acc_nxt = {8'd0, frame_byte};
            else begin
              pos = p + PW'(1) + PW'(v);
              if (pos > lim) begin vc_nxt = VC_NO_SNI; ph_nxt = PH_DONE; end
              else begin ph_nxt = PH_CMLEN; tgt_nxt = pos; end
            end
          end
          PH_EXTLEN: begin
            if (r == 0) acc_nxt = {8'd0, frame_byte};
            else begin
              pos = p + PW'(1);
              xend_nxt = p + PW'(1) + PW'(v);
              xcnt_nxt = '0;
              if (ext_limit == 8'd0 || pos + PW'(4) > xend_nxt || pos > lim) begin
                vc_nxt = VC_NO_SNI; ph_nxt = PH_DONE;
              end else begin ph_nxt = PH_EXTHDR; tgt_nxt = pos; end
            end
          end
          PH_EXTHDR: begin
            if (r == 0) acc_nxt = {8'd0, frame_byte};
            else begin
              xcnt_nxt = xcnt_r + 8'd1;
              if (v != 16'd0) ph_nxt = PH_EXTSKIP;
              else if (tgt_r + PW'(9) > xend_r || tgt_r + PW'(4) > lim) begin
                vc_nxt = VC_BAD_SNI; ph_nxt = PH_DONE;
              end else ph_nxt = PH_SNI;
            end
          end
          PH_EXTSKIP: begin
            if (r == 2) acc_nxt = {8'd0, frame_byte};
            else if (r == 3) begin
              pos = tgt_r + PW'(4) + PW'(v);
              if (xcnt_r >= ext_limit || pos + PW'(4) > xend_r || pos > lim) begin
                vc_nxt = VC_NO_SNI; ph_nxt = PH_DONE;
              end else begin ph_nxt = PH_EXTHDR; tgt_nxt = pos; end
            end
          end
          PH_SNI: begin
            if (r == 6) begin
              if (frame_byte != 8'd0) begin vc_nxt = VC_BAD_SNI; ph_nxt = PH_DONE; end
            end else if (r == 7) acc_nxt = {8'd0, frame_byte};
            else if (r == 8) begin
              if (v == 16'd0 || v > 16'(HMAX) || p + PW'(1) > lim) begin
                vc_nxt = VC_BAD_SNI; ph_nxt = PH_DONE;
              end else begin
                hlen_nxt = v[7:0]; hcnt_nxt = '0; ph_nxt = PH_NAME; tgt_nxt = p + PW'(1);
              end
            end
          end
          PH_NAME: begin
            is_host = 1'b1;
            hcnt_nxt = hcnt_r + 8'd1;
            if (hcnt_r + 8'd1 >= hlen_r) begin vc_nxt = VC_SNI_OK; ph_nxt = PH_DONE; end
          end
          default: ;
        endcase
      end
    end
    ph_e = ph_nxt; vc_e = vc_nxt; dest_e = dest_nxt;
    res1 = '0;
    res1.is_verdict = 1'b1;
    res1.verdict_code = (ph_e == PH_DONE) ? vc_e :
                        (ph_e == PH_ETH || ph_e == PH_IP || ph_e == PH_TCP) ? VC_NOT_TCP :
                        (ph_e == PH_TLS) ? VC_NOT_HELLO :
                        (ph_e == PH_SNI || ph_e == PH_NAME) ? VC_BAD_SNI : VC_NO_SNI;
    res1.sni_len = (res1.verdict_code == VC_SNI_OK) ? hlen_nxt : 8'd0;
    res1.dest_addr = (ph_e == PH_IP) ? 32'd0 : dest_e;
    if (frame_end) begin
      ph_nxt = PH_ETH; off_nxt = '0; tgt_nxt = '0; ps_nxt = '0; xend_nxt = '0;
      acc_nxt = '0; xcnt_nxt = '0; hlen_nxt = '0; hcnt_nxt = '0; dest_nxt = '0;
      vc_nxt = VC_NOT_TCP;
    end
  end

  always_comb begin
    res0 = '0;
    res0.host_char = lc;
    res0.host_index = hcnt_r;
  end
  assign res0_vld = step && is_host;
  assign res1_vld = step && frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_ETH; off_r <= '0; tgt_r <= '0; ps_r <= '0; xend_r <= '0;
      acc_r <= '0; xcnt_r <= '0; hlen_r <= '0; hcnt_r <= '0; dest_r <= '0;
      vc_r <= VC_NOT_TCP;
    end else if (step) begin
      ph_r <= ph_nxt; off_r <= off_nxt; tgt_r <= tgt_nxt; ps_r <= ps_nxt;
      xend_r <= xend_nxt; acc_r <= acc_nxt; xcnt_r <= xcnt_nxt; hlen_r <= hlen_nxt;
      hcnt_r <= hcnt_nxt; dest_r <= dest_nxt; vc_r <= vc_nxt;
    end
  end
endmodule

// ----- hw/rtl/tse_result_fifo.sv -----
// Back end: result queue taking up to two results per beat, one out per beat while out_stall is low.
// Depends on tse_pkg and the assertion macro header.
`include "tls_sni_extractor_unit_defines.svh"
module tse_result_fifo import tse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr0,
  input  logic     wr1,
  input  tse_res_t d0,
  input  tse_res_t d1,
  output logic     room,
  output logic     out_valid,
  input  logic     out_stall,
  output tse_res_t q
);
  localparam int unsigned DEPTH = 4;
  tse_res_t    mem_r [DEPTH];
  logic [1:0]  wp_r, rp_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign out_valid = cnt_r != 3'd0;
  assign pop  = out_valid && !out_stall;
  assign q    = mem_r[rp_r];
  assign room = cnt_r <= 3'd2;
  assign cnt_nxt = cnt_r + {2'd0, wr0} + {2'd0, wr1} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (wr0) mem_r[wp_r] <= d0;
    if (wr1) mem_r[wp_r + {1'b0, wr0}] <= d1;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + {1'b0, wr0} + {1'b0, wr1};
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_nxt;
    end
  end

  `TSE_ASSERT_IMP(a_no_over, clk, rst_n, wr0 || wr1, room, "result queue overflow")
  `TSE_ASSERT_NXT(a_cnt_step, clk, rst_n, 1'b1, cnt_r <= 3'(DEPTH), "queue count beyond depth")
  `TSE_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall && !wr0 && !wr1,
    out_valid && $stable(q), "stalled result changed")
endmodule

// ----- sim/tb_top.sv -----
// Testbench for tls_sni_extractor_unit: frame generator, byte-level SNI predictor and checker.
// Depends on tse_pkg and the extractor RTL; self-contained otherwise.
module tb_top import tse_pkg::*; ();

  typedef enum logic [4:0] {
    PH_ETH, PH_IP, PH_TCP, PH_TLS, PH_SID, PH_CSLEN, PH_CMLEN, PH_EXTLEN,
    PH_EXTHDR, PH_EXTSKIP, PH_SNI, PH_NAME, PH_DONE
  } phase_t;

  localparam int unsigned OFS_MAX = (1 << OFFSET_BITS_DEF) - 1;
  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst_n = 0;
  always #5 clk = ~clk;

  logic        in_valid = 0, in_stall;
  logic [7:0]  in_frame_byte = 0;
  logic        in_frame_end = 0;
  logic        out_valid, out_stall = 0;
  logic        out_is_verdict;
  logic [7:0]  out_host_char, out_host_index, out_sni_len;
  logic [2:0]  out_verdict_code;
  logic [31:0] out_dest_addr;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = CFG_MATCH_PORT;
  logic [15:0] cfg_wdata = 0;

  tls_sni_extractor_unit DUT (.*);

  // predictor state
  int unsigned port_cfg, depth_cfg, extlim_cfg;
  int unsigned ofs, tgt, pstart, acc, ext_end, ext_cnt, hlen, hcnt, dest, vcode;
  phase_t ph;

  tse_res_t expected_q[$];
  logic [8:0] pending_beats[$];   // {frame_end, byte}
  int   errors = 0, n_beats = 0, n_res = 0, n_frames = 0, n_names = 0;
  int   idle_pct = 0, stall_pct = 0, quiet = 0;
  bit   hold_off = 0;

  function automatic void clear_frame();
    ofs = 0; ph = PH_ETH; tgt = 0; pstart = 0; acc = 0; ext_end = 0;
    ext_cnt = 0; hlen = 0; hcnt = 0; dest = 0; vcode = 0;
  endfunction

  function automatic void conclude(int unsigned code);
    if (ph == PH_IP) dest = 0;
    vcode = code; ph = PH_DONE;
  endfunction

  function automatic int unsigned frame_end_code();
    if (ph == PH_DONE) return vcode;
    if (ph <= PH_TCP) return VC_NOT_TCP;
    if (ph == PH_TLS) return VC_NOT_HELLO;
    if (ph == PH_SNI || ph == PH_NAME) return VC_BAD_SNI;
    return VC_NO_SNI;
  endfunction

  function automatic bit beyond_depth(int unsigned pos);
    return pos > pstart + depth_cfg;
  endfunction

  function automatic void seek(phase_t nph, int unsigned pos);
    if (beyond_depth(pos)) conclude(VC_NO_SNI);
    else begin ph = nph; tgt = pos; end
  endfunction

  function automatic void open_extension(int unsigned pos);
    if (ext_cnt >= extlim_cfg || pos + 4 > ext_end || beyond_depth(pos)) conclude(VC_NO_SNI);
    else begin ph = PH_EXTHDR; tgt = pos; end
  endfunction

  // returns 1 when the byte belongs to the hostname
  function automatic bit parse_sni_byte(int unsigned p, int unsigned b);
    int unsigned r, v;
    if (ph == PH_DONE || p < tgt) return 0;
    r = p - tgt;
    v = ((acc & 8'hff) << 8) | b;
    case (ph)
      PH_ETH: begin
        if (r == 12) acc = b;
        else if (r == 13) begin
          if (v != 16'h0800) conclude(VC_NOT_TCP); else ph = PH_IP;
        end
      end
      PH_IP: begin
        if (r == 14) begin
          if ((b & 15) < 5) conclude(VC_NOT_TCP); else pstart = 14 + (b & 15) * 4;
        end else if (r == 23) begin
          if (b != 6) conclude(VC_NOT_TCP);
        end else if (r >= 30 && r <= 33) begin
          dest = (dest << 8) | b;
          if (r == 33) begin ph = PH_TCP; tgt = pstart; end
        end
      end
      PH_TCP: begin
        if (r == 2) acc = b;
        else if (r == 3) begin
          if (v != port_cfg) conclude(VC_NOT_TCP);
        end else if (r == 12) begin
          if ((b >> 4) < 5) conclude(VC_NOT_TCP); else acc = (b >> 4) * 4;
        end else if (r == 19) begin
          pstart = tgt + acc; tgt = pstart; ph = PH_TLS;
        end
      end
      PH_TLS: begin
        if (r == 0) begin
          if (b != 22) conclude(VC_NOT_HELLO);
        end else if (r == 1) acc = b;
        else if (r == 2) begin
          if (v != 16'h0301 && v != 16'h0302 && v != 16'h0303) conclude(VC_NOT_HELLO);
        end else if (r == 5) begin
          if (b != 1) conclude(VC_NOT_HELLO);
        end else if (r == 8) seek(PH_SID, pstart + 43);
      end
      PH_SID: seek(PH_CSLEN, p + 1 + b);
      PH_CSLEN: if (r == 0) acc = b; else seek(PH_CMLEN, p + 1 + v);
      PH_CMLEN: seek(PH_EXTLEN, p + 1 + b);
      PH_EXTLEN: begin
        if (r == 0) acc = b;
        else begin ext_end = p + 1 + v; ext_cnt = 0; open_extension(p + 1); end
      end
      PH_EXTHDR: begin
        if (r == 0) acc = b;
        else begin
          ext_cnt = (ext_cnt + 1) & 8'hff;
          if (v != 0) ph = PH_EXTSKIP;
          else if (tgt + 9 > ext_end || beyond_depth(tgt + 4)) conclude(VC_BAD_SNI);
          else ph = PH_SNI;
        end
      end
      PH_EXTSKIP: begin
        if (r == 2) acc = b;
        else if (r == 3) open_extension(tgt + 4 + v);
      end
      PH_SNI: begin
        if (r == 6) begin
          if (b != 0) conclude(VC_BAD_SNI);
        end else if (r == 7) acc = b;
        else if (r == 8) begin
          if (v == 0 || v > MAX_HOST_LEN_DEF || beyond_depth(p + 1)) conclude(VC_BAD_SNI);
          else begin hlen = v; hcnt = 0; ph = PH_NAME; tgt = p + 1; end
        end
      end
      PH_NAME: return 1;
      default: ;
    endcase
    acc &= 16'hffff;
    return 0;
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic fend);
    tse_res_t res;
    int unsigned code;
    if (ofs >= OFS_MAX) begin
      if (ph != PH_DONE) conclude(frame_end_code());
    end else begin
      if (parse_sni_byte(ofs, b)) begin
        res = '0;
        res.host_char = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        res.host_index = hcnt[7:0];
        expected_q.push_back(res);
        hcnt++;
        if (hcnt >= hlen) conclude(VC_SNI_OK);
      end
      ofs++;
    end
    if (fend) begin
      code = frame_end_code();
      res = '0;
      res.is_verdict = 1;
      res.verdict_code = code[2:0];
      res.sni_len = (code == VC_SNI_OK) ? hlen[7:0] : 8'd0;
      res.dest_addr = (ph == PH_IP) ? 32'd0 : dest;
      expected_q.push_back(res);
      clear_frame();
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_beat(in_frame_byte, in_frame_end);
        n_beats++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_beats.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
          {in_frame_end, in_frame_byte} <= pending_beats.pop_front();
          in_valid <= 1;
        end else in_valid <= 0;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    tse_res_t got, exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (out_valid && !out_stall) begin
        got = {out_is_verdict, out_host_char, out_host_index, out_verdict_code,
               out_sni_len, out_dest_addr};
        n_res++;
        if (expected_q.size() == 0) begin
          $error("unexpected result %h", got);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.is_verdict !== exp_r.is_verdict) begin
            $error("is_verdict exp %0d got %0d", exp_r.is_verdict, got.is_verdict); errors++; end
          if (got.host_char !== exp_r.host_char) begin
            $error("host_char exp %h got %h", exp_r.host_char, got.host_char); errors++; end
          if (got.host_index !== exp_r.host_index) begin
            $error("host_index exp %0d got %0d", exp_r.host_index, got.host_index); errors++; end
          if (got.verdict_code !== exp_r.verdict_code) begin
            $error("verdict_code exp %0d got %0d", exp_r.verdict_code, got.verdict_code);
            errors++; end
          if (got.sni_len !== exp_r.sni_len) begin
            $error("sni_len exp %0d got %0d", exp_r.sni_len, got.sni_len);
            errors++; end
          if (got.dest_addr !== exp_r.dest_addr) begin
            $error("dest_addr exp %h got %h", exp_r.dest_addr, got.dest_addr); errors++; end
          if (exp_r.is_verdict) n_frames++; else n_names++;
        end
      end
      if (quiet >= WATCHDOG) begin
        $display("watchdog expired, %0d results outstanding", expected_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // frame building
  function automatic void push_byte(int unsigned b, bit fend = 0);
    pending_beats.push_back({fend, b[7:0]});
  endfunction

  // random byte that mutates with probability pct, else the wanted one
  function automatic int unsigned pick(int unsigned good, int pct);
    return ($urandom_range(99) < pct) ? $urandom_range(255) : good;
  endfunction

  // full Ethernet/IPv4/TCP/TLS ClientHello; err_pct corrupts fields, cut truncates
  function automatic void build_hello(int unsigned port, int err_pct, int cut,
                                      int unsigned hn_len);
    int unsigned bytes[$];
    int unsigned ihl, doff, n_ext, l, sni_at, ext_len_at, xl;
    ihl = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
    doff = ($urandom_range(3) == 0) ? $urandom_range(5, 15) : 5;
    for (int i = 0; i < 12; i++) bytes.push_back($urandom_range(255));
    bytes.push_back(pick(8'h08, err_pct)); bytes.push_back(pick(8'h00, err_pct));
    bytes.push_back(pick(8'h40 | ihl, err_pct));
    for (int i = 1; i < 9; i++) bytes.push_back($urandom_range(255));
    bytes.push_back(pick(6, err_pct));
    for (int i = 10; i < ihl * 4; i++) bytes.push_back($urandom_range(255));
    bytes.push_back($urandom_range(255)); bytes.push_back($urandom_range(255));
    bytes.push_back(pick(port >> 8, err_pct)); bytes.push_back(pick(port & 255, err_pct));
    for (int i = 4; i < 12; i++) bytes.push_back($urandom_range(255));
    bytes.push_back(pick(doff << 4, err_pct));
    for (int i = 13; i < doff * 4; i++) bytes.push_back($urandom_range(255));
    bytes.push_back(pick(22, err_pct)); bytes.push_back(pick(3, err_pct));
    bytes.push_back(pick($urandom_range(1, 3), err_pct));
    bytes.push_back($urandom_range(255)); bytes.push_back($urandom_range(255));
    bytes.push_back(pick(1, err_pct));
    for (int i = 6; i < 43; i++) bytes.push_back($urandom_range(255));
    l = pick($urandom_range(0, 8), err_pct); bytes.push_back(l);
    for (int i = 0; i < l; i++) bytes.push_back($urandom_range(255));
    l = $urandom_range(1, 6) * 2;
    bytes.push_back(pick(0, err_pct)); bytes.push_back(l);
    for (int i = 0; i < l; i++) bytes.push_back($urandom_range(255));
    l = $urandom_range(1, 3); bytes.push_back(l);
    for (int i = 0; i < l; i++) bytes.push_back($urandom_range(255));
    ext_len_at = bytes.size(); bytes.push_back(0); bytes.push_back(0);
    n_ext = $urandom_range(0, 3);
    for (int e = 0; e < n_ext; e++) begin
      xl = $urandom_range(0, 6);
      bytes.push_back($urandom_range(255)); bytes.push_back($urandom_range(1, 255));
      bytes.push_back(0); bytes.push_back(xl);
      for (int i = 0; i < xl; i++) bytes.push_back($urandom_range(255));
    end
    sni_at = bytes.size();
    bytes.push_back(0); bytes.push_back(0);
    bytes.push_back(0); bytes.push_back(hn_len + 5);
    bytes.push_back(0); bytes.push_back(hn_len + 3);
    bytes.push_back(pick(0, err_pct));
    bytes.push_back(pick(hn_len >> 8, err_pct)); bytes.push_back(pick(hn_len & 255, err_pct));
    for (int i = 0; i < hn_len; i++)
      bytes.push_back(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(65, 90));
    for (int i = 0; i < $urandom_range(0, 4); i++) bytes.push_back($urandom_range(255));
    xl = bytes.size() - ext_len_at - 2;
    if ($urandom_range(99) < err_pct) xl = $urandom_range(0, xl + 4);
    bytes[ext_len_at] = xl >> 8; bytes[ext_len_at + 1] = xl & 255;
    if (cut > 0 && cut < bytes.size()) bytes = bytes[0:cut-1];
    foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1);
  endfunction

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val[15:0];
    case (idx)
      CFG_MATCH_PORT:  port_cfg = val & 16'hffff;
      CFG_PARSE_DEPTH: depth_cfg = val & 16'hffff;
      default:         extlim_cfg = val & 8'hff;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(int n_frames_to_send, int ip, int sp);
    int k;
    idle_pct = ip; stall_pct = sp;
    for (int f = 0; f < n_frames_to_send; f++) begin
      case ($urandom_range(9))
        0: begin
          k = $urandom_range(1, 30);
          for (int i = 0; i < k; i++) push_byte($urandom_range(255), i == k - 1);
        end
        1: build_hello(port_cfg, 0, $urandom_range(1, 120), $urandom_range(1, 20));
        2: build_hello(port_cfg, 8, 0, $urandom_range(1, 20));
        3: build_hello($urandom_range(65535), 0, 0, 4);
        default: build_hello(port_cfg, 0, 0, $urandom_range(1, 24));
      endcase
      if (f == n_frames_to_send / 2) begin
        while (pending_beats.size() > 0) @(posedge clk);
        hold_off = 1;
        while (in_valid || expected_q.size() > 0) @(posedge clk);
        hold_off = 0;
      end
    end
    drain();
  endtask

  initial begin
    port_cfg = MATCH_PORT_RST; depth_cfg = PARSE_DEPTH_RST; extlim_cfg = EXT_LIMIT_RST;
    clear_frame();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // directed: lone end byte, wrong ethertype, name of maximum length, hello cut short
    push_byte(8'hff, 1);
    for (int i = 0; i < 14; i++) push_byte(i == 12 ? 8'h86 : 8'h00, i == 13);
    build_hello(port_cfg, 0, 0, 255);
    build_hello(port_cfg, 0, 140, 30);
    drain();
    random_phase(2, 0, 0);
    write_reg(CFG_MATCH_PORT, 16'hffff);
    write_reg(CFG_PARSE_DEPTH, 0);
    write_reg(CFG_EXT_LIMIT, 0);
    random_phase(1, 87, 0);
    write_reg(CFG_MATCH_PORT, 0);
    write_reg(CFG_PARSE_DEPTH, 16'hffff);
    write_reg(CFG_EXT_LIMIT, 255);
    random_phase(1, 0, 87);
    write_reg(CFG_PARSE_DEPTH, $urandom_range(60, 120));
    write_reg(CFG_EXT_LIMIT, 2);
    random_phase(1, 13, 13);
    write_reg(CFG_MATCH_PORT, 443);
    write_reg(CFG_PARSE_DEPTH, 512);
    write_reg(CFG_EXT_LIMIT, 1);
    random_phase(1, 40, 40);
    $display("%0d beats in, %0d frame verdicts and %0d hostname bytes checked",
             n_beats, n_frames, n_names);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ----- tls_sni_extractor_unit.f -----
+incdir+hw/rtl
hw/rtl/tse_pkg.sv
hw/rtl/tse_parser.sv
hw/rtl/tse_result_fifo.sv
hw/rtl/tls_sni_extractor_unit.sv
sim/tb_top.sv
